>>> hw/rtl/vdt_pkg.sv
// Shared constants, types and register codes of the vertex deduplication table.
// Depends on nothing; every other file of the block but vdt_ram imports it.
package vdt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int NUM_COMP    = 8;
    localparam int COMP_W      = 32;
    localparam int VERTEX_W    = NUM_COMP * COMP_W;
    localparam int TOL_W       = 16;
    localparam int OUT_IDX_W   = 8;
    localparam int DUP_W       = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_MATCH_TOL = '0;

    // Component 0 is pos_x, then pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z.
    typedef logic [NUM_COMP-1:0][COMP_W-1:0] t_vertex;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] vertex_index;
        logic                 was_found;
        logic                 table_full;
        logic [DUP_W-1:0]     duplicate_total;
    } t_result;

endpackage

>>> hw/rtl/vertex_dedup_table_unit.sv
// Top level of the vertex deduplication table: APB register, request queue and scan engine.
// Depends on vdt_pkg, vdt_front, vdt_back and vdt_ram.
//
// Each input request is one vertex of eight signed Q16.16 components. The block scans
// its stored entries from index 0 upward and returns the first entry whose components
// all lie within the tolerance register of the request; otherwise it appends the vertex,
// or flags the table as full when no entry is free. A match adds one to a saturating
// duplicate counter, which every result reports.
// Input and output channels use valid and ready. The scan engine reads the stored entries
// through the single read port of the vertex store, which returns one entry per cycle; a
// scan covers up to the entries stored and ends early on a match. A two-entry queue takes
// further requests while a scan runs, and a finished result waits in the output register
// while the receiver stalls; the engine then holds before writing. The tolerance register
// lies at byte address 0; the user must write it only while the block idles, which the
// block does not check. Reset empties the table, clears the duplicate counter and the
// tolerance; no clearing pass is needed, since only entries below the fill count are ever
// read.
module vertex_dedup_table_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vdt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [vdt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [vdt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [31:0]                i_pos_x,
    input  logic signed [31:0]                i_pos_y,
    input  logic signed [31:0]                i_pos_z,
    input  logic signed [31:0]                i_tex_u,
    input  logic signed [31:0]                i_tex_v,
    input  logic signed [31:0]                i_norm_x,
    input  logic signed [31:0]                i_norm_y,
    input  logic signed [31:0]                i_norm_z,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [7:0]                        o_vertex_index,
    output logic                              o_was_found,
    output logic                              o_table_full,
    output logic [31:0]                       o_duplicate_total
);
    import vdt_pkg::*;

    logic [TOL_W-1:0]     r_tolerance;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;
    t_vertex              in_vertex;
    t_vertex              head;
    logic                 head_valid, head_pop;
    t_result              result;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= '0;
        end else if (cfg_write && (reg_idx == REG_MATCH_TOL)) begin
            r_tolerance <= pwdata[TOL_W-1:0];
        end
    end

    assign prdata = (reg_idx == REG_MATCH_TOL) ? APB_DATA_W'(r_tolerance) : '0;

    assign in_vertex[0] = i_pos_x;
    assign in_vertex[1] = i_pos_y;
    assign in_vertex[2] = i_pos_z;
    assign in_vertex[3] = i_tex_u;
    assign in_vertex[4] = i_tex_v;
    assign in_vertex[5] = i_norm_x;
    assign in_vertex[6] = i_norm_y;
    assign in_vertex[7] = i_norm_z;

    vdt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_vertex     (in_vertex),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_head_pop   (head_pop)
    );

    vdt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_head_pop   (head_pop),
        .i_tolerance  (r_tolerance),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (result)
    );

    assign o_vertex_index    = result.vertex_index;
    assign o_was_found       = result.was_found;
    assign o_table_full      = result.table_full;
    assign o_duplicate_total = result.duplicate_total;

endmodule

>>> hw/rtl/vdt_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Stand-alone; used by the scan engine for the vertex store.
module vdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/vdt_front.sv
// Front end: accepts vertex requests and holds them in a short queue for the scan engine.
// Depends on vdt_pkg.
module vdt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  vdt_pkg::t_vertex i_vertex,
    output logic            o_head_valid,
    output vdt_pkg::t_vertex o_head,
    input  logic            i_head_pop
);
    import vdt_pkg::*;

    t_vertex           r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              push, pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + QPTR_W'(1);
    endfunction

    assign o_in_ready   = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_slot[r_rd_ptr];
    assign push         = i_in_valid && o_in_ready;
    assign pop          = i_head_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_vertex;
        end
    end

endmodule

>>> hw/rtl/vdt_back.sv
// Back end: scans the vertex store one entry per cycle, appends new vertices and
// holds the result in an output register. Depends on vdt_pkg and vdt_ram.
module vdt_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_head_valid,
    input  vdt_pkg::t_vertex            i_head,
    output logic                        o_head_pop,
    input  logic [vdt_pkg::TOL_W-1:0]   i_tolerance,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output vdt_pkg::t_result            o_result
);
    import vdt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} t_state;

    t_state           r_state, n_state;
    t_vertex          r_vertex, n_vertex;
    logic [IDX_W-1:0] r_scan_idx, n_scan_idx;
    logic [IDX_W-1:0] r_hit_idx, n_hit_idx;
    logic             r_found, n_found;
    logic [CNT_W-1:0] r_count, n_count;
    logic [DUP_W-1:0] r_dup, n_dup;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    logic                       ram_we, ram_re;
    logic [IDX_W-1:0]           ram_raddr;
    logic [VERTEX_W-1:0]        ram_rdata;
    t_vertex                    stored;
    logic [NUM_COMP-1:0]        comp_ok;
    logic                       match, last, slot_free, has_room;
    logic [IDX_W+OUT_IDX_W-1:0] idx_ext;

    vdt_ram #(
        .WIDTH (VERTEX_W),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (r_vertex),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    function automatic logic within_tol(input logic [COMP_W-1:0] a,
                                        input logic [COMP_W-1:0] b,
                                        input logic [TOL_W-1:0]  tol);
        logic signed [COMP_W:0] diff;
        logic        [COMP_W:0] mag;
        diff = $signed({a[COMP_W-1], a}) - $signed({b[COMP_W-1], b});
        mag  = diff[COMP_W] ? -diff : diff;
        return mag <= (COMP_W + 1)'(tol);
    endfunction

    assign stored = ram_rdata;

    always_comb begin
        for (int c = 0; c < NUM_COMP; c++) begin
            comp_ok[c] = within_tol(stored[c], r_vertex[c], i_tolerance);
        end
    end

    assign match     = &comp_ok;
    assign last      = ((CNT_W'(r_scan_idx) + CNT_W'(1)) == r_count);
    assign slot_free = !r_out_valid || i_out_ready;
    assign has_room  = (r_count < CNT_W'(TABLE_DEPTH));

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (r_state == S_IDLE) begin
            ram_re = i_head_valid && (r_count != '0);
        end else if (r_state == S_SCAN) begin
            ram_re    = !match && !last;
            ram_raddr = r_scan_idx + IDX_W'(1);
        end
        ram_we = (r_state == S_FINISH) && slot_free && !r_found && has_room;
    end

    always_comb begin
        n_state     = r_state;
        n_vertex    = r_vertex;
        n_scan_idx  = r_scan_idx;
        n_hit_idx   = r_hit_idx;
        n_found     = r_found;
        n_count     = r_count;
        n_dup       = r_dup;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_head_pop  = 1'b0;
        idx_ext     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    o_head_pop = 1'b1;
                    n_vertex   = i_head;
                    n_scan_idx = '0;
                    n_found    = 1'b0;
                    n_state    = (r_count == '0) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (match) begin
                    n_found   = 1'b1;
                    n_hit_idx = r_scan_idx;
                    n_state   = S_FINISH;
                end else if (last) begin
                    n_state = S_FINISH;
                end else begin
                    n_scan_idx = r_scan_idx + IDX_W'(1);
                end
            end
            S_FINISH: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    if (r_found) begin
                        n_dup              = (r_dup == '1) ? r_dup : r_dup + DUP_W'(1);
                        idx_ext            = {{OUT_IDX_W{1'b0}}, r_hit_idx};
                        n_out.was_found    = 1'b1;
                    end else if (has_room) begin
                        idx_ext = {{OUT_IDX_W{1'b0}}, r_count[IDX_W-1:0]};
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_out.table_full = 1'b1;
                    end
                    n_out.vertex_index    = idx_ext[OUT_IDX_W-1:0];
                    n_out.duplicate_total = n_dup;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dup       <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dup       <= n_dup;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
        end
        r_vertex   <= n_vertex;
        r_scan_idx <= n_scan_idx;
        r_hit_idx  <= n_hit_idx;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("Entry count exceeds the table depth.");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_scan_idx) < r_count))
        else $error("Scan index has passed the stored entries.");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.was_found && r_out.table_full))
        else $error("A result is both a match and a full-table miss.");

    a_dup_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_dup >= $past(r_dup)))
        else $error("Duplicate counter decreased.");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> ($past(r_state) == S_FINISH))
        else $error("A result appeared without a finished scan.");

endmodule
